@@ rtl/mfc_pkg.sv @@
// Shared types and constants for the clamped median filter.
`timescale 1ns / 1ps
`default_nettype none

package mfc_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 11;
  localparam int RADIUS_REG_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd100;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd100;
  localparam logic [RADIUS_REG_W-1:0] RADIUS_RESET = 3'd4;

  // Fill values for window cells outside the active radius; equal numbers
  // of each keep the middle rank unchanged.
  localparam logic [PIX_W-1:0] PAD_LO = 8'h00;
  localparam logic [PIX_W-1:0] PAD_HI = 8'hFF;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/median_filter_clamped.sv @@
// Top level of the streaming 2D median filter with clamped borders.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: pixel_in[7:0]; tuser: drain
//  m_*      out  m_tvalid/m_tready  tdata: filtered_pixel[7:0]; tlast: frame_end
//  cfg_*    in   cfg_valid/cfg_ready cfg_addr: register index; cfg_data: value
//
// One item per clock while results drain; a result passes two read stages,
// one window stage and two stages per result bit before the result queue.
// The 32-entry result queue and a credit count stall input only when full.
// Reset clears all counters and the pipeline; row stores are not cleared.
// Configuration is taken in any cycle; write it only while nothing is in flight.
`timescale 1ns / 1ps
`default_nettype none

module median_filter_clamped #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,  // [7:0] pixel_in
  input  logic                                 s_tuser,  // [0] drain
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [7:0]                           m_tdata,  // [7:0] filtered_pixel
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int SIDE      = 2 * MAX_RADIUS + 1;
  localparam int NWIN      = SIDE * SIDE;
  localparam int RES_DEPTH = 32;
  localparam int PCW       = $clog2(RES_DEPTH + 1);
  localparam int QAW       = $clog2(RES_DEPTH);
  localparam int MED_LAT   = 2 * mfc_pkg::PIX_W;

  logic [mfc_pkg::WIDTH_REG_W-1:0]  frame_width;
  logic [mfc_pkg::HEIGHT_REG_W-1:0] frame_height;
  logic [mfc_pkg::RADIUS_REG_W-1:0] window_radius;

  logic                                 acc;
  logic                                 pop;
  logic                                 has_out;
  mfc_pkg::ctl_t                        win_ctl;
  logic [NWIN-1:0][mfc_pkg::PIX_W-1:0]  win_vals;
  logic                                 med_valid;
  mfc_pkg::res_t                        med_res;
  mfc_pkg::res_t                        head;
  logic [QAW:0]                         q_count;
  logic [PCW-1:0]                       pending;

  assign cfg_ready = 1'b1;
  assign s_tready  = (pending < PCW'(RES_DEPTH));
  assign acc       = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;
  assign m_tdata   = head.pix;
  assign m_tlast   = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= mfc_pkg::WIDTH_RESET;
      frame_height  <= mfc_pkg::HEIGHT_RESET;
      window_radius <= mfc_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        mfc_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        mfc_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        mfc_pkg::REG_WINDOW_RADIUS: window_radius <= cfg_data[mfc_pkg::RADIUS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // results owed: counted at accept, released when the transaction leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      unique case ({acc && has_out, pop})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  mfc_front #(
    .MAX_RADIUS (MAX_RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .pix        (s_tdata),
    .drain      (s_tuser),
    .width_reg  (frame_width),
    .height_reg (frame_height),
    .radius_reg (window_radius),
    .has_out    (has_out),
    .win_ctl    (win_ctl),
    .win_vals   (win_vals)
  );

  mfc_median #(
    .SIDE (SIDE)
  ) u_median (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (win_ctl),
    .in_vals   (win_vals),
    .out_valid (med_valid),
    .out_res   (med_res)
  );

  mfc_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (med_valid),
    .push_data (med_res),
    .pop       (pop),
    .not_empty (m_tvalid),
    .head      (head),
    .count     (q_count)
  );

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PCW'(RES_DEPTH))
    else $error("result credits exceed queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (rst)
    PCW'(q_count) <= pending)
    else $error("queued results exceed outstanding credits");

  a_rank_latency: assert property (@(posedge clk) disable iff (rst)
    win_ctl.valid |-> ##MED_LAT med_valid)
    else $error("window did not leave the rank pipeline on time");
`endif

endmodule

`default_nettype wire

@@ rtl/mfc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/mfc_fifo.sv @@
// Result queue between the rank pipeline and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module mfc_fifo #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mfc_pkg::res_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output mfc_pkg::res_t head,
  output logic [AW:0]   count
);

  mfc_pkg::res_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result queue popped while empty");
`endif

endmodule

`default_nettype wire

@@ rtl/mfc_median.sv @@
// Bitwise rank pipeline: resolves the middle value one bit per two stages.
`timescale 1ns / 1ps
`default_nettype none

module mfc_median #(
  parameter int SIDE = 9,
  localparam int N   = SIDE * SIDE,
  localparam int MID = N / 2,
  localparam int CW  = $clog2(SIDE + 1),
  localparam int TW  = $clog2(N + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mfc_pkg::ctl_t                        in_ctl,
  input  logic [N-1:0][mfc_pkg::PIX_W-1:0]     in_vals,
  output logic                                 out_valid,
  output mfc_pkg::res_t                        out_res
);

  localparam int PW = mfc_pkg::PIX_W;

  mfc_pkg::ctl_t          a_ctl  [PW+1];
  logic [N-1:0][PW-1:0]   a_vals [PW+1];
  logic [PW-1:0]          a_pref [PW+1];

  assign a_ctl[0]  = in_ctl;
  assign a_vals[0] = in_vals;
  assign a_pref[0] = '0;

  for (genvar s = 0; s < PW; s++) begin : g_bit
    localparam int B = PW - 1 - s;

    logic [PW-1:0]              cand;
    logic [SIDE-1:0][CW-1:0]    grp_cnt;
    logic [SIDE-1:0][CW-1:0]    grp_q;
    mfc_pkg::ctl_t              mid_ctl;
    logic [N-1:0][PW-1:0]       mid_vals;
    logic [PW-1:0]              mid_cand;
    logic [PW-1:0]              mid_pref;
    logic [TW-1:0]              total;
    mfc_pkg::ctl_t              q_ctl;
    logic [N-1:0][PW-1:0]       q_vals;
    logic [PW-1:0]              q_pref;

    assign cand = a_pref[s] | (PW'(1) << B);

    // count values below the candidate, one group per window row
    always_comb begin
      for (int g = 0; g < SIDE; g++) begin
        grp_cnt[g] = '0;
        for (int e = 0; e < SIDE; e++) begin
          if (a_vals[s][g*SIDE+e] < cand) begin
            grp_cnt[g] = grp_cnt[g] + CW'(1);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mid_ctl <= '0;
      end else begin
        mid_ctl <= a_ctl[s];
      end
    end

    always_ff @(posedge clk) begin
      grp_q    <= grp_cnt;
      mid_vals <= a_vals[s];
      mid_cand <= cand;
      mid_pref <= a_pref[s];
    end

    always_comb begin
      total = '0;
      for (int g = 0; g < SIDE; g++) begin
        total = total + TW'(grp_q[g]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        q_ctl <= '0;
      end else begin
        q_ctl <= mid_ctl;
      end
    end

    // keep the bit when the middle rank is not below the candidate
    always_ff @(posedge clk) begin
      q_vals <= mid_vals;
      q_pref <= (total <= TW'(MID)) ? mid_cand : mid_pref;
    end

    assign a_ctl[s+1]  = q_ctl;
    assign a_vals[s+1] = q_vals;
    assign a_pref[s+1] = q_pref;
  end

  assign out_valid    = a_ctl[PW].valid;
  assign out_res.last = a_ctl[PW].last;
  assign out_res.pix  = a_pref[PW];

endmodule

`default_nettype wire

@@ rtl/mfc_front.sv @@
// Front end: position counters, row stores and window gathering.
`timescale 1ns / 1ps
`default_nettype none

module mfc_front #(
  parameter int MAX_RADIUS = 4,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int SIDE = 2 * MAX_RADIUS + 1,
  localparam int NWIN = SIDE * SIDE
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  acc,
  input  logic [mfc_pkg::PIX_W-1:0]             pix,
  input  logic                                  drain,
  input  logic [mfc_pkg::WIDTH_REG_W-1:0]       width_reg,
  input  logic [mfc_pkg::HEIGHT_REG_W-1:0]      height_reg,
  input  logic [mfc_pkg::RADIUS_REG_W-1:0]      radius_reg,
  output logic                                  has_out,
  output mfc_pkg::ctl_t                         win_ctl,
  output logic [NWIN-1:0][mfc_pkg::PIX_W-1:0]   win_vals
);

  localparam int PW    = mfc_pkg::PIX_W;
  localparam int MID   = NWIN / 2;
  localparam int NBANK = 2 * MAX_RADIUS + 2;
  localparam int BW    = $clog2(NBANK);
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int WDW   = $clog2(MAX_WIDTH + 1);
  localparam int HDW   = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int CNTW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                + MAX_RADIUS + 1);

  logic [WDW-1:0] w_eff;
  logic [HDW-1:0] h_eff;
  logic [RW-1:0]  r_eff;
  logic [CNTW-1:0] rw_prod;
  logic [CNTW-1:0] lag;

  logic [COLW-1:0] in_col;
  logic [HDW-1:0]  in_row;
  logic [BW-1:0]   wbank;
  logic [COLW-1:0] rcol;
  logic [HDW-1:0]  rrow;
  logic [BW-1:0]   rbank;
  logic [COLW-1:0] out_col;
  logic [HDW-1:0]  out_row;
  logic [CNTW-1:0] items_seen;
  logic [CNTW-1:0] cnt_next;

  logic            rd_act;
  logic            last_now;
  logic            wr_en;
  logic [COLW-1:0] wcol;
  logic [WDW-1:0]  in_col_inc;
  logic [WDW-1:0]  rcol_inc;
  logic [WDW-1:0]  out_col_inc;

  logic [SIDE-1:0][BW-1:0] bank_sel;
  logic [RW-1:0]           room_l;
  logic [RW-1:0]           room_r;

  // stage 1: read issue
  logic                    s1_rd;
  logic                    s1_out;
  logic                    s1_last;
  logic [COLW-1:0]         s1_col;
  logic [SIDE-1:0][BW-1:0] s1_bank;
  logic [RW-1:0]           s1_rl;
  logic [RW-1:0]           s1_rr;

  // stage 2: read data back
  logic                    s2_rd;
  logic                    s2_out;
  logic                    s2_last;
  logic [SIDE-1:0][BW-1:0] s2_bank;
  logic [RW-1:0]           s2_rl;
  logic [RW-1:0]           s2_rr;

  logic [NBANK-1:0][PW-1:0]           rdata;
  logic [SIDE-1:0][SIDE-1:0][PW-1:0]  hist;
  logic [SIDE-1:0][SIDE-1:0][PW-1:0]  hist_next;
  logic [NWIN-1:0][PW-1:0]            win_next;

  // saturate the frame and radius registers into their legal ranges
  always_comb begin
    if (width_reg == '0) begin
      w_eff = WDW'(1);
    end else if (int'(width_reg) > MAX_WIDTH) begin
      w_eff = WDW'(MAX_WIDTH);
    end else begin
      w_eff = WDW'(width_reg);
    end
    if (height_reg == '0) begin
      h_eff = HDW'(1);
    end else if (int'(height_reg) > MAX_HEIGHT) begin
      h_eff = HDW'(MAX_HEIGHT);
    end else begin
      h_eff = HDW'(height_reg);
    end
    if (radius_reg == '0) begin
      r_eff = RW'(1);
    end else if (int'(radius_reg) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_reg);
    end
  end

  assign rw_prod  = CNTW'(r_eff) * CNTW'(w_eff);
  assign lag      = rw_prod + CNTW'(r_eff);
  assign cnt_next = items_seen + 1'b1;
  assign rd_act   = (cnt_next > rw_prod);
  assign has_out  = (cnt_next > lag);
  assign last_now = has_out && (out_row >= h_eff - 1'b1)
                    && (WDW'(out_col) >= w_eff - 1'b1);

  assign wr_en       = acc && !drain && (in_row < h_eff);
  assign wcol        = (WDW'(in_col) < w_eff) ? in_col : COLW'(w_eff - 1'b1);
  assign in_col_inc  = WDW'(in_col) + 1'b1;
  assign rcol_inc    = WDW'(rcol) + 1'b1;
  assign out_col_inc = WDW'(out_col) + 1'b1;

  // row store banks for each window row offset, clamped at top and bottom
  always_comb begin
    int off;
    int below;
    int b;
    below = int'(h_eff) - 1 - int'(rrow);
    if (below < 0) begin
      below = 0;
    end
    for (int k = 0; k < SIDE; k++) begin
      off = k - MAX_RADIUS;
      if (off < 0 && int'(rrow) < -off) begin
        off = -int'(rrow);
      end else if (off > 0 && below < off) begin
        off = below;
      end
      b = int'(rbank) + off;
      if (b < 0) begin
        b = b + NBANK;
      end else if (b >= NBANK) begin
        b = b - NBANK;
      end
      bank_sel[k] = BW'(b);
    end
  end

  // column room on each side of the output position
  always_comb begin
    int right;
    right = int'(w_eff) - 1 - int'(out_col);
    room_l = (int'(out_col) < MAX_RADIUS) ? RW'(out_col) : RW'(MAX_RADIUS);
    room_r = (right < MAX_RADIUS) ? RW'(right) : RW'(MAX_RADIUS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col     <= '0;
      in_row     <= '0;
      wbank      <= '0;
      rcol       <= '0;
      rrow       <= '0;
      rbank      <= '0;
      out_col    <= '0;
      out_row    <= '0;
      items_seen <= '0;
    end else if (acc) begin
      if (last_now) begin
        in_col     <= '0;
        in_row     <= '0;
        wbank      <= '0;
        rcol       <= '0;
        rrow       <= '0;
        rbank      <= '0;
        out_col    <= '0;
        out_row    <= '0;
        items_seen <= '0;
      end else begin
        items_seen <= cnt_next;
        if (wr_en) begin
          if (in_col_inc >= w_eff) begin
            in_col <= '0;
            in_row <= in_row + 1'b1;
            wbank  <= (wbank == BW'(NBANK - 1)) ? '0 : wbank + 1'b1;
          end else begin
            in_col <= COLW'(in_col_inc);
          end
        end
        if (rd_act) begin
          if (rcol_inc >= w_eff) begin
            rcol  <= '0;
            rrow  <= rrow + 1'b1;
            rbank <= (rbank == BW'(NBANK - 1)) ? '0 : rbank + 1'b1;
          end else begin
            rcol <= COLW'(rcol_inc);
          end
        end
        if (has_out) begin
          if (out_col_inc >= w_eff) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= COLW'(out_col_inc);
          end
        end
      end
    end
  end

  for (genvar gb = 0; gb < NBANK; gb++) begin : g_bank
    mfc_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
    ) u_row (
      .clk   (clk),
      .we    (wr_en && (wbank == BW'(gb))),
      .waddr (wcol),
      .wdata (pix),
      .raddr (s1_col),
      .rdata (rdata[gb])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_rd   <= 1'b0;
      s1_out  <= 1'b0;
      s2_rd   <= 1'b0;
      s2_out  <= 1'b0;
      win_ctl <= '0;
    end else begin
      s1_rd         <= acc && rd_act;
      s1_out        <= acc && has_out;
      s2_rd         <= s1_rd;
      s2_out        <= s1_out;
      win_ctl.valid <= s2_out;
      win_ctl.last  <= s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_last  <= last_now;
    s1_col   <= rcol;
    s1_bank  <= bank_sel;
    s1_rl    <= room_l;
    s1_rr    <= room_r;
    s2_last  <= s1_last;
    s2_bank  <= s1_bank;
    s2_rl    <= s1_rl;
    s2_rr    <= s1_rr;
    hist     <= hist_next;
    win_vals <= win_next;
  end

  // advance the column history by the freshly read column
  always_comb begin
    hist_next = hist;
    if (s2_rd) begin
      for (int k = 0; k < SIDE; k++) begin
        hist_next[0][k] = rdata[s2_bank[k]];
      end
      for (int j = 1; j < SIDE; j++) begin
        hist_next[j] = hist[j-1];
      end
    end
  end

  // gather the window; cells beyond the radius get balanced fill values
  always_comb begin
    int ki;
    int kj;
    int c;
    int j;
    for (int i = 0; i < NWIN; i++) begin
      ki = i / SIDE - MAX_RADIUS;
      kj = i % SIDE - MAX_RADIUS;
      c  = kj;
      if (c < 0 && int'(s2_rl) < -c) begin
        c = -int'(s2_rl);
      end else if (c > 0 && int'(s2_rr) < c) begin
        c = int'(s2_rr);
      end
      j = int'(r_eff) - c;
      if (j < 0) begin
        j = 0;
      end else if (j > SIDE - 1) begin
        j = SIDE - 1;
      end
      if (ki <= int'(r_eff) && -ki <= int'(r_eff)
          && kj <= int'(r_eff) && -kj <= int'(r_eff)) begin
        win_next[i] = hist_next[j][ki + MAX_RADIUS];
      end else if (i < MID) begin
        win_next[i] = mfc_pkg::PAD_LO;
      end else begin
        win_next[i] = mfc_pkg::PAD_HI;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/median_filter_clamped_checker.sv @@
// Scoreboard for the clamped median filter: predicts and checks each result.
`timescale 1ns / 1ps

module median_filter_clamped_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] pixel_in
  input  logic                           s_tuser,   // [0] drain
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [7:0]                     m_tdata,   // [7:0] filtered_pixel
  input  logic                           m_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mfc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);

  localparam int RMAX  = 4;
  localparam int WMAX  = 1024;
  localparam int HMAX  = 1024;
  localparam int DEPTH = 2 * RMAX * WMAX + 2 * RMAX + 1;

  logic [mfc_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [mfc_pkg::HEIGHT_REG_W-1:0] height_reg;
  logic [mfc_pkg::RADIUS_REG_W-1:0] radius_reg;
  logic [mfc_pkg::PIX_W-1:0]        row_ring [DEPTH];
  int                               in_col, in_row, out_col, out_row, frame_items;
  mfc_pkg::res_t                    expected_q[$];

  function automatic int sat(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the filter model by one input transaction.
  task automatic filter_step(input logic [7:0] pix, input logic drain);
    int            w, h, r, lag, col, ny, nx, cnt, acc;
    int            hist [256];
    mfc_pkg::res_t res;
    w = sat(width_reg, WMAX);
    h = sat(height_reg, HMAX);
    r = sat(radius_reg, RMAX);
    lag = r * w + r;
    frame_items++;
    if (!drain && in_row < h) begin
      col = in_col < w ? in_col : w - 1;
      row_ring[(in_row * w + col) % DEPTH] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    if (frame_items <= lag) return;
    foreach (hist[i]) hist[i] = 0;
    cnt = 0;
    for (int ky = -r; ky <= r; ky++) begin
      for (int kx = -r; kx <= r; kx++) begin
        ny = clamp(out_row + ky, h - 1);
        nx = clamp(out_col + kx, w - 1);
        hist[row_ring[(ny * w + nx) % DEPTH]]++;
        cnt++;
      end
    end
    acc = 0;
    res.pix = '0;
    for (int v = 0; v < 256; v++) begin
      acc += hist[v];
      if (acc > cnt / 2) begin
        res.pix = v[7:0];
        break;
      end
    end
    res.last = (out_row >= h - 1) && (out_col >= w - 1);
    expected_q = {expected_q, res};
    if (res.last) begin
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_items = 0;
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  always @(posedge clk) begin
    mfc_pkg::res_t want;
    int            errs;
    errs = 0;
    if (rst) begin
      width_reg <= mfc_pkg::WIDTH_RESET;
      height_reg <= mfc_pkg::HEIGHT_RESET;
      radius_reg <= mfc_pkg::RADIUS_RESET;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_items = 0;
      expected_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_addr)
          mfc_pkg::REG_FRAME_WIDTH:
            width_reg <= cfg_data[mfc_pkg::WIDTH_REG_W-1:0];
          mfc_pkg::REG_FRAME_HEIGHT:
            height_reg <= cfg_data[mfc_pkg::HEIGHT_REG_W-1:0];
          mfc_pkg::REG_WINDOW_RADIUS:
            radius_reg <= cfg_data[mfc_pkg::RADIUS_REG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) filter_step(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        checked <= checked + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction: filtered_pixel %0d frame_end %0b",
                 m_tdata, m_tlast);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata !== want.pix) begin
            $error("filtered_pixel mismatch: expected %0d, actual %0d", want.pix, m_tdata);
            errs++;
          end
          if (m_tlast !== want.last) begin
            $error("frame_end mismatch: expected %0b, actual %0b", want.last, m_tlast);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_q.size();
  end

endmodule

@@ tb/median_filter_clamped_test.sv @@
// Stimulus, watchdog and verdict for the clamped median filter.
`timescale 1ns / 1ps

module median_filter_clamped_test;

  localparam int IDLE_LIMIT = 5000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata = '0;   // [7:0] pixel_in
  logic                           s_tuser = 1'b0; // [0] drain
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;        // [7:0] filtered_pixel
  logic                           m_tlast;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mfc_pkg::CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [mfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                             fail_count, pending, checked;
  int                             stall_cycles = 0, items_sent = 0, frames = 0;
  int                             hold_left = 0;
  bit                             held = 1'b0;

  median_filter_clamped dut (.*);
  median_filter_clamped_checker scoreboard (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Quiet window where neither side idles.
  function automatic bit may_idle();
    return !(items_sent >= 600 && items_sent < 900) && $urandom_range(99) < 13;
  endfunction

  // Long receiver hold-off once during the tall frame.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!held && frames == 4 && items_sent > 150) begin
      held <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !may_idle();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("median_filter_clamped test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [mfc_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[mfc_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] pix, input logic drain);
    bit ready_seen;
    if (may_idle()) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pix;
    s_tuser <= drain;
    // sample ready once it has settled, ahead of the edge that may accept
    do begin
      #1 ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    items_sent++;
  endtask

  function automatic logic [7:0] pick_pixel(int style);
    case (style)
      0: return $urandom_range(1) ? 8'hFF : 8'h00;
      1: return 8'(100 + $urandom_range(7));
      default: return 8'($urandom);
    endcase
  endfunction

  // One frame: program sizes, stream pixels, then flush with drain items and extra pixels.
  task automatic run_frame(input int w_raw, input int h_raw, input int r_raw, input int style);
    int w, h, r;
    w = w_raw < 1 ? 1 : (w_raw > 1024 ? 1024 : w_raw);
    h = h_raw < 1 ? 1 : (h_raw > 1024 ? 1024 : h_raw);
    r = r_raw < 1 ? 1 : (r_raw > 4 ? 4 : r_raw);
    write_reg(mfc_pkg::REG_FRAME_WIDTH, w_raw);
    write_reg(mfc_pkg::REG_FRAME_HEIGHT, h_raw);
    write_reg(mfc_pkg::REG_WINDOW_RADIUS, r_raw);
    for (int i = 0; i < w * h; i++) send_pixel(pick_pixel(style), 1'b0);
    // Extra pixels past the frame are dropped, so mix some into the flush.
    for (int i = 0; i < r * w + r; i++)
      send_pixel(8'($urandom), $urandom_range(3) != 0);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    frames++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_frame(0, 0, 0, 0);
    run_frame(3, 2, 7, 0);
    run_frame(5, 1, 1, 2);
    run_frame(1, 4, 3, 2);
    run_frame(1, 2047, 1, 0);
    while (items_sent < 1330)
      run_frame($urandom_range(15) == 0 ? $urandom_range(13, 20) : $urandom_range(12),
                $urandom_range(6), $urandom_range(7), $urandom_range(2));
    repeat (40) @(posedge clk);
    $display("Covered %0d frames, %0d input items and %0d checked results,",
             frames, items_sent, checked);
    $display("including saturated sizes and radii and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("median_filter_clamped test passed");
    end else begin
      $display("median_filter_clamped test failed");
    end
    $finish;
  end

endmodule

@@ median_filter_clamped.f @@
rtl/mfc_pkg.sv
rtl/mfc_ram.sv
rtl/mfc_fifo.sv
rtl/mfc_median.sv
rtl/mfc_front.sv
rtl/median_filter_clamped.sv
tb/median_filter_clamped_checker.sv
tb/median_filter_clamped_test.sv
